// File: src/plist_pkg.sv
// Package with the shared types and constants of the positional list engine.
package plist_pkg;

	localparam int CAPACITY = 16;
	localparam int VAL_W = 32;
	localparam int POS_W = 4;
	localparam int TYPE_W = 3;
	localparam int STAT_W = 2;
	localparam int LEN_W = 5;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [TYPE_W-1:0] {
		REQ_INSERT_AT = 3'd0,
		REQ_APPEND    = 3'd1,
		REQ_EXTRACT_AT = 3'd2,
		REQ_EXTRACT_HEAD = 3'd3,
		REQ_EXTRACT_TAIL = 3'd4,
		REQ_UPDATE_AT = 3'd5
	} req_type_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_NOPOS = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic             shift_up;
		logic             shift_dn;
		logic             load;
		logic [IDX_W-1:0] pos;
		logic [VAL_W-1:0] data;
	} cell_ctrl_t;

endpackage

// File: src/plist_req_if.sv
// Request channel of the positional list engine.
interface plist_req_if
	import plist_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [TYPE_W-1:0] req_type;
	logic [POS_W-1:0]  position;
	logic [VAL_W-1:0]  value;

	modport source (output valid, req_type, position, value, input ready);
	modport sink (input valid, req_type, position, value, output ready);
endinterface

// File: src/plist_rsp_if.sv
// Response channel of the positional list engine.
interface plist_rsp_if
	import plist_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [VAL_W-1:0]  read_value;
	logic [STAT_W-1:0] status;
	logic [LEN_W-1:0]  length;

	modport source (output valid, read_value, status, length, input ready);
	modport sink (input valid, read_value, status, length, output ready);
endinterface

// File: src/positional_list_engine_top.sv
// Top level of the positional list engine: decoder, cell chain and response register.
// A response becomes valid in the cycle after its request is accepted.
// Throughput: one request per cycle while responses are taken; every cell
// compares its index with the position and shifts in the same cycle.
// Reset clears the element count and the response valid; cell contents stay
// undefined until written and are never read beyond the current length.
module positional_list_engine_top
	import plist_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	plist_req_if.sink          req,
	plist_rsp_if.source        rsp
);

	logic             accept;
	cell_ctrl_t       cell_ctrl;
	status_t          status;
	logic [CNT_W-1:0] count;
	logic [CNT_W-1:0] count_next;
	logic [VAL_W-1:0] cell_data [CAPACITY];
	logic [VAL_W-1:0] rd_value;

	logic              rsp_valid_q;
	logic [VAL_W-1:0]  read_value_q;
	logic [STAT_W-1:0] status_q;
	logic [LEN_W-1:0]  length_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept = req.valid && req.ready;

	plist_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.req_type   (req.req_type),
		.position   (req.position),
		.value      (req.value),
		.cell_ctrl  (cell_ctrl),
		.status     (status),
		.count      (count),
		.count_next (count_next)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VAL_W-1:0] left;
		logic [VAL_W-1:0] right;

		if (i == 0) begin : g_head
			assign left = cell_ctrl.data;
		end else begin : g_mid
			assign left = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right = cell_data[i];
		end else begin : g_body
			assign right = cell_data[i+1];
		end

		plist_cell #(
			.INDEX (i)
		) u_cell (
			.clk   (clk),
			.ctrl  (cell_ctrl),
			.left  (left),
			.right (right),
			.data  (cell_data[i])
		);
	end

	assign rd_value = cell_ctrl.shift_dn ? cell_data[cell_ctrl.pos] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= rd_value;
			status_q <= status;
			length_q <= LEN_W'(count_next);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.read_value = read_value_q;
	assign rsp.status = status_q;
	assign rsp.length = length_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(CAPACITY))
		else $error("element count exceeds capacity");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid_q)
		else $error("accepted request produced no response");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q != ST_OK |-> read_value_q == '0)
		else $error("failed request returned a nonzero value");

	a_len_match: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> length_q == LEN_W'(count))
		else $error("response length differs from element count");

endmodule

// File: src/plist_cell.sv
// One list cell: holds an element and moves it to or from its neighbors.
module plist_cell
	import plist_pkg::*;
#(
	parameter int INDEX = 0
) (
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  logic [VAL_W-1:0] left,
	input  logic [VAL_W-1:0] right,
	output logic [VAL_W-1:0] data
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [VAL_W-1:0] data_q;
	logic [VAL_W-1:0] data_d;
	logic             at_pos;
	logic             above_pos;

	assign at_pos = (MY_IDX == ctrl.pos);
	assign above_pos = (MY_IDX > ctrl.pos);

	always_comb begin
		data_d = data_q;
		if (ctrl.shift_up) begin
			if (at_pos) begin
				data_d = ctrl.data;
			end else if (above_pos) begin
				data_d = left;
			end
		end else if (ctrl.shift_dn) begin
			if (at_pos || above_pos) begin
				data_d = right;
			end
		end else if (ctrl.load && at_pos) begin
			data_d = ctrl.data;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

// File: src/plist_ctrl.sv
// Request decoder and element counter of the positional list engine.
module plist_ctrl
	import plist_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [TYPE_W-1:0] req_type,
	input  logic [POS_W-1:0]  position,
	input  logic [VAL_W-1:0]  value,
	output cell_ctrl_t        cell_ctrl,
	output status_t           status,
	output logic [CNT_W-1:0]  count,
	output logic [CNT_W-1:0]  count_next
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic [CNT_W-1:0] count_m1;
	logic [CNT_W-1:0] pos_ext;
	logic             full;
	logic             empty;
	cell_ctrl_t       dec;

	assign full = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);
	assign count_m1 = count_q - 1'b1;
	assign pos_ext = CNT_W'(position);

	always_comb begin
		dec = '0;
		dec.data = value;
		status = ST_OK;
		count_d = count_q;
		unique case (req_type_t'(req_type))
			REQ_INSERT_AT: begin
				if (full) begin
					status = ST_FULL;
				end else if (pos_ext > count_q) begin
					status = ST_NOPOS;
				end else begin
					dec.shift_up = 1'b1;
					dec.pos = IDX_W'(position);
					count_d = count_q + 1'b1;
				end
			end
			REQ_APPEND: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					dec.shift_up = 1'b1;
					dec.pos = count_q[IDX_W-1:0];
					count_d = count_q + 1'b1;
				end
			end
			REQ_EXTRACT_AT, REQ_UPDATE_AT: begin
				if (empty) begin
					status = ST_EMPTY;
				end else if (pos_ext >= count_q) begin
					status = ST_NOPOS;
				end else begin
					dec.pos = IDX_W'(position);
					if (req_type_t'(req_type) == REQ_UPDATE_AT) begin
						dec.load = 1'b1;
					end else begin
						dec.shift_dn = 1'b1;
						count_d = count_m1;
					end
				end
			end
			REQ_EXTRACT_HEAD: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					dec.shift_dn = 1'b1;
					count_d = count_m1;
				end
			end
			REQ_EXTRACT_TAIL: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					dec.shift_dn = 1'b1;
					dec.pos = count_m1[IDX_W-1:0];
					count_d = count_m1;
				end
			end
			default: begin
			end
		endcase
	end

	// Cells only move on an accepted request; the position still steers the read mux.
	always_comb begin
		cell_ctrl = dec;
		cell_ctrl.shift_up = dec.shift_up && accept;
		cell_ctrl.shift_dn = dec.shift_dn && accept;
		cell_ctrl.load = dec.load && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	assign count = count_q;
	assign count_next = count_d;

endmodule
